@@ rtl/rrq_pkg.sv @@
package rrq_pkg;

  localparam int MaxProcs  = 16;
  localparam int Terminals = 4;
  localparam int IdxW      = $clog2(MaxProcs);
  localparam int CntW      = $clog2(MaxProcs + 1);

  localparam logic [2:0] TermNone = 3'd7;

  // Transaction kinds.
  localparam logic [2:0] KindAdd       = 3'd0;
  localparam logic [2:0] KindExpire    = 3'd1;
  localparam logic [2:0] KindExit      = 3'd2;
  localparam logic [2:0] KindSetStatus = 3'd3;
  localparam logic [2:0] KindWakeWr    = 3'd4;
  localparam logic [2:0] KindWakeRd    = 3'd5;
  localparam logic [2:0] KindFindWr    = 3'd6;
  localparam logic [2:0] KindNop       = 3'd7;

  // Status codes.
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoneRun  = 3'd1;
  localparam logic [2:0] StExitEmpt = 3'd2;
  localparam logic [2:0] StExitIdle = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  // Configuration register indexes.
  localparam logic CfgFbPid = 1'b0;
  localparam logic CfgFbDly = 1'b1;

  typedef struct packed {
    logic [15:0] pid;
    logic [15:0] delay;
    logic        waiting;
    logic [2:0]  rd;
    logic [2:0]  ww;
    logic [2:0]  wr;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SCAN, S_ROTATE, S_SHIFT, S_DONE, S_OUT
  } state_t;

  // Per-entry predicate set, evaluated by the shared compare unit.
  typedef struct packed {
    logic pid_eq;
    logic ready0;
    logic ready_idle;
    logic delay0;
    logic ww_eq;
    logic rd_eq;
    logic wr_eq;
  } match_t;

  function automatic logic is_clear(slot_t s);
    return s.waiting == 1'b0 && s.rd == TermNone && s.ww == TermNone && s.wr == TermNone;
  endfunction

endpackage

@@ rtl/rrq_match.sv @@
module rrq_match
  import rrq_pkg::*;
(
  input  slot_t       slot,
  input  logic [15:0] pid,
  input  logic [15:0] fb_dly,
  input  logic [1:0]  terminal,
  output match_t      m
);

  logic [2:0] term3;
  logic       term_ok;

  // Shared compare unit applied to one entry per cycle.
  always_comb begin
    term3      = {1'b0, terminal};
    term_ok    = 32'(terminal) < Terminals;
    m.pid_eq     = slot.pid == pid;
    m.ready0     = is_clear(slot) && slot.delay == 16'd0;
    m.ready_idle = is_clear(slot) && slot.delay == fb_dly;
    m.delay0     = slot.delay == 16'd0;
    m.ww_eq      = term_ok && slot.ww == term3;
    m.rd_eq      = term_ok && slot.rd == term3;
    m.wr_eq      = term_ok && slot.wr == term3;
  end

endmodule

@@ rtl/round_robin_run_queue.sv @@
// Round-robin run queue of up to MaxProcs process entries; entry 0 is the
// running process.
// in_ channel: one scheduler event per transaction, its kind on in_tuser.
// out_ channel: one result per event. cfg_ port: index 0 sets the pid of the
// idle process, index 1 the delay that marks it as the fallback choice;
// write only while no event is in flight.
// A sequencer walks the queue one entry per cycle through a single compare
// unit and moves the chosen entry to the front one slot per cycle.
// out_tvalid rises once the event has passed from S_DECIDE through any scan, rotation
// or shift, then S_DONE and S_OUT; in_tready is low meanwhile. in_tready returns in
// the same cycle that the result is loaded, so the next event may be accepted while
// that result still waits for out_tready. When the receiver stalls with a result
// pending, the following result is held in the sequencer until the output register
// frees up.
// Reset empties the queue, sets the idle pid to 1 and the fallback delay to
// 65535.
module round_robin_run_queue
  import rrq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // kind[2:0]
  input  logic [2:0]  in_tuser,
  // pid[15:0], delay[31:16], waiting[32], read_term[35:33],
  // write_wait_term[38:36], writing_term[41:39], terminal[43:42], zeros
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // head_pid[15:0], head_valid[16], switched[17], found[18],
  // found_pid[34:19], status[37:35], count[42:38], zeros
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  slot_t       q_r [MaxProcs];
  slot_t       q_nxt [MaxProcs];
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [15:0] fb_pid_r, fb_dly_r;
  state_t      st_r, st_nxt;
  logic [46:0] in_r, in_nxt;
  logic [IdxW-1:0] i_r, i_nxt, hit_r, hit_nxt;
  logic        pass_r, pass_nxt;      // 0 = zero delay pass, 1 = idle delay pass
  logic        go_r, go_nxt;
  logic        rot_r, rot_nxt;        // expiry rotation applied, choosing now
  logic        sw_r, sw_nxt, fnd_r, fnd_nxt;
  logic [15:0] fpid_r, fpid_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic [47:0] out_r, out_nxt;
  logic        ov_r, ov_nxt;

  logic [2:0]  kind;
  slot_t       in_slot;
  slot_t       cur;
  match_t      m;
  logic [CntW-1:0] last;

  assign kind            = in_r[2:0];
  assign in_slot.pid     = in_r[18:3];
  assign in_slot.delay   = in_r[34:19];
  assign in_slot.waiting = in_r[35];
  assign in_slot.rd      = in_r[38:36];
  assign in_slot.ww      = in_r[41:39];
  assign in_slot.wr      = in_r[44:42];
  assign cur             = q_r[i_r];
  assign last            = cnt_r - 1'b1;

  rrq_match u_match (
    .slot(cur), .pid(in_slot.pid), .fb_dly(fb_dly_r),
    .terminal(in_r[46:45]), .m(m)
  );

  assign in_tready  = st_r == S_IDLE;
  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  // State and storage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      ov_r <= 1'b0;
      fb_pid_r <= 16'd1;
      fb_dly_r <= 16'hFFFF;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
      if (cfg_we && cfg_index == CfgFbPid) fb_pid_r <= cfg_wdata;
      if (cfg_we && cfg_index == CfgFbDly) fb_dly_r <= cfg_wdata;
    end
    q_r <= q_nxt;
    in_r <= in_nxt;
    i_r <= i_nxt;
    hit_r <= hit_nxt;
    pass_r <= pass_nxt;
    go_r <= go_nxt;
    rot_r <= rot_nxt;
    sw_r <= sw_nxt;
    fnd_r <= fnd_nxt;
    fpid_r <= fpid_nxt;
    stat_r <= stat_nxt;
    out_r <= out_nxt;
  end

  // Sequencer.
  always_comb begin
    st_nxt = st_r; q_nxt = q_r; cnt_nxt = cnt_r; in_nxt = in_r;
    i_nxt = i_r; hit_nxt = hit_r; pass_nxt = pass_r; go_nxt = go_r;
    rot_nxt = rot_r;
    sw_nxt = sw_r; fnd_nxt = fnd_r; fpid_nxt = fpid_r; stat_nxt = stat_r;
    out_nxt = out_r; ov_nxt = ov_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          in_nxt = {in_tdata[43:0], in_tuser};
          i_nxt = '0; pass_nxt = 1'b0; go_nxt = 1'b0; rot_nxt = 1'b0;
          sw_nxt = 1'b0; fnd_nxt = 1'b0; fpid_nxt = '0; stat_nxt = StOk;
          st_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        st_nxt = S_DONE;
        case (kind)
          KindAdd: begin
            if (32'(cnt_r) >= MaxProcs) stat_nxt = StFull;
            else begin
              for (int k = MaxProcs - 1; k > 0; k--)
                if (k < 32'(cnt_r) + 1) q_nxt[k] = q_r[k-1];
              q_nxt[0] = in_slot;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          KindExpire: begin
            if (cnt_r == '0) stat_nxt = StNoneRun;
            else begin
              go_nxt = q_r[0].pid != fb_pid_r;
              i_nxt = IdxW'(1);
              st_nxt = (cnt_r == CntW'(1)) ? S_ROTATE : S_SCAN;
              if (cnt_r == CntW'(1) && q_r[0].pid == fb_pid_r) st_nxt = S_DONE;
            end
          end
          KindExit: begin
            if (cnt_r == '0) stat_nxt = StExitEmpt;
            else if (q_r[0].pid == fb_pid_r) stat_nxt = StExitIdle;
            else begin
              for (int k = 0; k < MaxProcs - 1; k++) q_nxt[k] = q_r[k+1];
              cnt_nxt = cnt_r - 1'b1;
              if (cnt_r == CntW'(1)) stat_nxt = StNoneRun;
              else begin
                i_nxt = '0; st_nxt = S_SCAN;
              end
            end
          end
          default: begin
            if (cnt_r != '0 && kind != KindNop) st_nxt = S_SCAN;
          end
        endcase
      end
      // One entry per cycle through the compare unit.
      S_SCAN: begin
        if (kind == KindExit || rot_r) begin
          // Choose pass: first ready zero delay entry, else first idle delay one.
          if ((!pass_r && m.ready0) || (pass_r && m.ready_idle)) begin
            hit_nxt = i_r; st_nxt = S_SHIFT; sw_nxt = 1'b1;
          end else if (CntW'(i_r) == last) begin
            if (!pass_r) begin
              pass_nxt = 1'b1; i_nxt = '0;
            end else begin
              stat_nxt = StNoneRun; st_nxt = S_DONE;
            end
          end else i_nxt = i_r + 1'b1;
        end else begin
          case (kind)
            KindExpire: begin
              if (!go_r) begin
                // Idle head check: any other entry with delay zero.
                if (m.delay0) begin
                  go_nxt = 1'b1; st_nxt = S_ROTATE;
                end else if (CntW'(i_r) == last) st_nxt = S_DONE;
                else i_nxt = i_r + 1'b1;
              end else st_nxt = S_ROTATE;
            end
            KindSetStatus: begin
              if (m.pid_eq) begin
                q_nxt[i_r] = in_slot;
                q_nxt[i_r].pid = cur.pid;
                fnd_nxt = 1'b1; st_nxt = S_DONE;
              end else if (CntW'(i_r) == last) st_nxt = S_DONE;
              else i_nxt = i_r + 1'b1;
            end
            KindWakeWr, KindWakeRd, KindFindWr: begin
              if ((kind == KindWakeWr && m.ww_eq) || (kind == KindWakeRd && m.rd_eq) ||
                  (kind == KindFindWr && m.wr_eq)) begin
                fnd_nxt = 1'b1; st_nxt = S_DONE;
                if (kind == KindWakeWr) q_nxt[i_r].ww = TermNone;
                if (kind == KindWakeRd) q_nxt[i_r].rd = TermNone;
                if (kind == KindFindWr) fpid_nxt = cur.pid;
              end else if (CntW'(i_r) == last) st_nxt = S_DONE;
              else i_nxt = i_r + 1'b1;
            end
            default: st_nxt = S_DONE;
          endcase
        end
      end
      // Expiry: head to tail, then choose on the rotated queue. A failed
      // choose undoes the rotation in S_DONE.
      S_ROTATE: begin
        for (int k = 0; k < MaxProcs - 1; k++)
          if (k < 32'(last)) q_nxt[k] = q_r[k+1];
        q_nxt[last[IdxW-1:0]] = q_r[0];
        rot_nxt = 1'b1;
        i_nxt = '0; pass_nxt = 1'b0; go_nxt = 1'b1;
        st_nxt = S_SCAN;
      end
      // Move the chosen entry to the front, one slot per cycle.
      S_SHIFT: begin
        if (hit_r == '0) st_nxt = S_DONE;
        else begin
          q_nxt[hit_r] = q_r[hit_r - 1'b1];
          q_nxt[hit_r - 1'b1] = q_r[hit_r];
          hit_nxt = hit_r - 1'b1;
        end
      end
      S_DONE: begin
        // Failed choose after a rotation: undo it (tail back to head).
        if (rot_r && stat_r == StNoneRun) begin
          for (int k = MaxProcs - 1; k > 0; k--)
            if (k < 32'(cnt_r)) q_nxt[k] = q_r[k-1];
          q_nxt[0] = q_r[last[IdxW-1:0]];
        end
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          out_nxt = '0;
          out_nxt[15:0]  = (cnt_r != '0) ? q_r[0].pid : 16'd0;
          out_nxt[16]    = cnt_r != '0;
          out_nxt[17]    = sw_r;
          out_nxt[18]    = fnd_r;
          out_nxt[34:19] = fpid_r;
          out_nxt[37:35] = stat_r;
          out_nxt[42:38] = 5'(cnt_r);
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

endmodule
